[rtl/qdl_pkg.sv]
`default_nettype none

package qdl_pkg;

  // Field widths of one beat
  localparam int unsigned IndexW = 13;
  localparam int unsigned DepthW = 25;
  localparam int unsigned CoordW = 12;
  localparam int unsigned CountW = 13;
  localparam int unsigned TileW  = 13;
  localparam int unsigned ChildW = 4 * IndexW;

  // One node entry: has-depth flag, depth, four children
  localparam int unsigned NodeW = 1 + DepthW + ChildW;

  // 1.0 in the depth fraction
  localparam logic [DepthW-1:0] DepthOne = 25'h100_0000;

  // Operation codes carried in tuser
  localparam logic OpWrite  = 1'b0;
  localparam logic OpLookup = 1'b1;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StIssue = 4'b0010,
    StEval  = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  // One accepted input beat, unpacked
  typedef struct packed {
    logic                    op;
    logic [IndexW-1:0]       index;
    logic                    has_depth;
    logic [DepthW-1:0]       depth;
    logic [ChildW-1:0]       children;
    logic [CoordW-1:0]       win_first;
    logic [CountW-1:0]       win_count;
    logic [CoordW-1:0]       sample_x;
    logic [CoordW-1:0]       sample_y;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [DepthW-1:0] depth;
  } result_t;

endpackage

`default_nettype wire

[rtl/qdl_walker.sv]
`default_nettype none

module qdl_walker #(
  parameter int unsigned NODE_SLOTS = 4096,
  parameter int unsigned MAX_LEVELS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        item_valid_i,
  input  wire qdl_pkg::item_t              item_i,
  input  wire logic [qdl_pkg::TileW-1:0]   tile_size_i,
  output logic                             idle_o,
  output logic                             res_valid_o,
  output qdl_pkg::result_t                 res_o,
  input  wire logic                        res_ready_i
);

  localparam int unsigned AW = $clog2(NODE_SLOTS);
  localparam int unsigned LW = $clog2(MAX_LEVELS + 1);
  localparam logic [16:0] SlotsW = 17'(NODE_SLOTS);
  localparam logic [LW-1:0] LastLvl = LW'(MAX_LEVELS - 1);

  // Node store, single write port, registered read
  logic [qdl_pkg::NodeW-1:0] mem_q [NODE_SLOTS];
  logic [qdl_pkg::NodeW-1:0] rdata_q;

  qdl_pkg::state_e state_q, state_d;

  logic [qdl_pkg::CoordW-1:0] node_q, node_d;
  logic [qdl_pkg::CoordW-1:0] ox_q, ox_d, oy_q, oy_d;
  logic [qdl_pkg::TileW-1:0]  size_q, size_d;
  logic [qdl_pkg::CoordW-1:0] first_q, first_d;
  logic [qdl_pkg::CoordW+1:0] end_q, end_d;
  logic [LW-1:0]              lvl_q, lvl_d;
  logic                       found_q, found_d;
  logic [qdl_pkg::DepthW-1:0] depth_q, depth_d;

  logic                       accept;
  logic                       idx_ok;
  logic [16:0]                idx_ext;
  logic [14:0]                in_end;
  logic                       root_in;
  logic [16:0]                wr_ext;
  logic [16:0]                rd_ext;

  logic                       n_has;
  logic [qdl_pkg::DepthW-1:0] n_depth;
  logic [qdl_pkg::IndexW-1:0] n_child [4];
  logic                       any_child;
  logic [qdl_pkg::TileW-1:0]  half;
  logic                       cx, cy;
  logic [qdl_pkg::IndexW-1:0] next;
  logic                       next_in;

  assign accept  = item_valid_i && (state_q == qdl_pkg::StIdle);
  assign idle_o  = (state_q == qdl_pkg::StIdle);

  // Check the incoming slot index against the store
  assign idx_ext = 17'(item_i.index[qdl_pkg::IndexW-2:0]);
  assign idx_ok  = !item_i.index[qdl_pkg::IndexW-1] && (idx_ext < SlotsW);
  assign in_end  = 15'(item_i.win_first) + 15'(item_i.win_count);
  assign root_in = (item_i.index[qdl_pkg::CoordW-1:0] >= item_i.win_first) &&
                   (15'(item_i.index[qdl_pkg::CoordW-1:0]) < in_end);

  // Write a node on a write beat
  assign wr_ext = idx_ext;
  always_ff @(posedge clk_i) begin
    if (accept && item_i.op == qdl_pkg::OpWrite && idx_ok) begin
      mem_q[wr_ext[AW-1:0]] <= {item_i.has_depth, item_i.depth, item_i.children};
    end
  end

  // Read the current node
  assign rd_ext = 17'(node_q);
  always_ff @(posedge clk_i) begin
    if (state_q == qdl_pkg::StIssue) begin
      rdata_q <= mem_q[rd_ext[AW-1:0]];
    end
  end

  // Split the fetched node
  assign n_has   = rdata_q[qdl_pkg::NodeW-1];
  assign n_depth = rdata_q[qdl_pkg::NodeW-2 -: qdl_pkg::DepthW];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      n_child[i] = rdata_q[i*qdl_pkg::IndexW +: qdl_pkg::IndexW];
    end
  end
  assign any_child = !n_child[0][qdl_pkg::IndexW-1] || !n_child[1][qdl_pkg::IndexW-1] ||
                     !n_child[2][qdl_pkg::IndexW-1] || !n_child[3][qdl_pkg::IndexW-1];

  // Quadrant pick and window check of the chosen child
  assign half    = size_q >> 1;
  assign cx      = (13'(ox_q) >= half);
  assign cy      = (13'(oy_q) >= half);
  assign next    = n_child[{cy, cx}];
  assign next_in = !next[qdl_pkg::IndexW-1] &&
                   (17'(next[qdl_pkg::CoordW-1:0]) < SlotsW) &&
                   (next[qdl_pkg::CoordW-1:0] >= first_q) &&
                   (14'(next[qdl_pkg::CoordW-1:0]) < end_q);

  // Sequence one level per read
  always_comb begin
    state_d = state_q;
    node_d  = node_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    size_d  = size_q;
    first_d = first_q;
    end_d   = end_q;
    lvl_d   = lvl_q;
    found_d = found_q;
    depth_d = depth_q;
    unique case (state_q)
      qdl_pkg::StIdle: begin
        if (accept && item_i.op == qdl_pkg::OpLookup) begin
          node_d  = item_i.index[qdl_pkg::CoordW-1:0];
          ox_d    = item_i.sample_x;
          oy_d    = item_i.sample_y;
          size_d  = tile_size_i;
          first_d = item_i.win_first;
          end_d   = in_end[qdl_pkg::CoordW+1:0];
          lvl_d   = '0;
          found_d = 1'b0;
          depth_d = qdl_pkg::DepthOne;
          if (idx_ok && item_i.win_count != '0 && tile_size_i != '0 && root_in) begin
            state_d = qdl_pkg::StIssue;
          end else begin
            state_d = qdl_pkg::StDone;
          end
        end
      end
      qdl_pkg::StIssue: begin
        state_d = qdl_pkg::StEval;
      end
      qdl_pkg::StEval: begin
        if (n_has) begin
          found_d = 1'b1;
          depth_d = n_depth;
        end
        if (!any_child || size_q <= 13'd1 || !next_in || lvl_q == LastLvl) begin
          state_d = qdl_pkg::StDone;
        end else begin
          node_d  = next[qdl_pkg::CoordW-1:0];
          ox_d    = cx ? ox_q - half[qdl_pkg::CoordW-1:0] : ox_q;
          oy_d    = cy ? oy_q - half[qdl_pkg::CoordW-1:0] : oy_q;
          size_d  = half;
          lvl_d   = lvl_q + LW'(1);
          state_d = qdl_pkg::StIssue;
        end
      end
      qdl_pkg::StDone: begin
        if (res_ready_i) begin
          state_d = qdl_pkg::StIdle;
        end
      end
      default: state_d = qdl_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qdl_pkg::StIdle;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    size_q  <= size_d;
    first_q <= first_d;
    end_q   <= end_d;
    found_q <= found_d;
    depth_q <= depth_d;
  end

  assign res_valid_o = (state_q == qdl_pkg::StDone);
  assign res_o.found = found_q;
  assign res_o.depth = depth_q;

  // Level count stays within the walk limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LastLvl)
    else $error("level counter beyond limit");

  // A node is only read while it lies inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qdl_pkg::StIssue) |-> (node_q >= first_q && 14'(node_q) < end_q))
    else $error("walk left the node window");

  // Region never collapses to zero while walking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qdl_pkg::StIssue || state_q == qdl_pkg::StEval) |-> size_q != '0)
    else $error("zero region size during walk");

  // A taken result frees the walker at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i) |=> idle_o)
    else $error("walker did not return to idle");

endmodule

`default_nettype wire

[rtl/quadtree_depth_lookup.sv]
// Quadtree depth lookup over a node store.
// Input beats arrive on the s_axis channel; tuser[0] selects the operation:
// 0 writes one node into the store (no result), 1 runs a lookup that yields
// exactly one result beat on m_axis (tuser[0] = found, tdata = depth).
// tile_size is written through the cfg channel, which is always ready; write
// it only while no lookup is in flight.
// A write is stored when it is accepted. A lookup that visits L nodes reads and
// evaluates each in turn; a rejected lookup skips the walk and reads nothing.
// Each level costs one registered read of the single-port node store plus an
// evaluate state; s_axis_tready stays low until the result moves into the
// output register. L is at most log2(tile_size) + 1 and at most MAX_LEVELS.
// The result sits in an output register; while the receiver stalls, the
// block still accepts node writes, and a following lookup finishes its walk
// and waits for that register to drain.
// Reset sets tile_size to 128 and empties the pipeline. The node store is not
// cleared: write every node before a lookup can reach it.
`default_nettype none

module quadtree_depth_lookup #(
  parameter int unsigned NODE_SLOTS = 4096,
  parameter int unsigned MAX_LEVELS = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // cfg: tile_size
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [12:0]   cfg_data_i,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // index[12:0], node_has_depth[13], node_depth[38:14], child_a[51:39],
  // child_b[64:52], child_c[77:65], child_d[90:78], window_first[102:91],
  // window_count[115:103], sample_x[127:116], sample_y[139:128], zero pad
  input  wire logic [143:0]  s_axis_tdata,
  // op[0]
  input  wire logic [0:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // depth[24:0], zero pad
  output logic [31:0]        m_axis_tdata,
  // found[0]
  output logic [0:0]         m_axis_tuser
);

  logic [qdl_pkg::TileW-1:0] tile_q;
  qdl_pkg::item_t            item;
  logic                      walk_idle;
  logic                      res_valid;
  logic                      res_ready;
  qdl_pkg::result_t          res;
  logic                      out_valid_q;
  qdl_pkg::result_t          out_q;

  // Hold the tile size register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_q <= 13'd128;
    end else if (cfg_valid_i) begin
      tile_q <= cfg_data_i;
    end
  end

  // Unpack the input beat
  assign item.op        = s_axis_tuser[0];
  assign item.index     = s_axis_tdata[12:0];
  assign item.has_depth = s_axis_tdata[13];
  assign item.depth     = s_axis_tdata[38:14];
  assign item.children  = s_axis_tdata[90:39];
  assign item.win_first = s_axis_tdata[102:91];
  assign item.win_count = s_axis_tdata[115:103];
  assign item.sample_x  = s_axis_tdata[127:116];
  assign item.sample_y  = s_axis_tdata[139:128];

  assign s_axis_tready = walk_idle;

  qdl_walker #(
    .NODE_SLOTS (NODE_SLOTS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_i       (item),
    .tile_size_i  (tile_q),
    .idle_o       (walk_idle),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  // Output register: load when empty or draining
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.depth};
  assign m_axis_tuser  = out_q.found;

endmodule

`default_nettype wire

[bench/qdl_depth_checker.sv]
module qdl_depth_checker #(
  parameter int NodeSlots = 4096,
  parameter int MaxLevels = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  input  wire logic         cfg_ready_i,
  input  wire logic [12:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  // index, node_has_depth, node_depth, child_a..child_d, window_first,
  // window_count, sample_x, sample_y, zero pad
  input  wire logic [143:0] s_axis_tdata,
  // op
  input  wire logic [0:0]   s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // depth, zero pad
  input  wire logic [31:0]  m_axis_tdata,
  // found
  input  wire logic [0:0]   m_axis_tuser,
  output int unsigned       mismatches_o,
  output int unsigned       awaiting_o
);

  localparam int unsigned ReportLimit = 10;
  localparam int unsigned IndexW = qdl_pkg::IndexW;
  localparam int unsigned DepthW = qdl_pkg::DepthW;
  localparam int unsigned TileW  = qdl_pkg::TileW;
  localparam int unsigned ChildW = qdl_pkg::ChildW;
  localparam int unsigned SlotW  = $clog2(NodeSlots);

  // Shadow copy of the node store and the tile size
  logic [DepthW:0]   depth_mem [NodeSlots];
  logic [ChildW-1:0] child_mem [NodeSlots];
  logic [TileW-1:0]  tile_size_q;

  // Lookup results still owed by the block, oldest first
  qdl_pkg::result_t depth_results [$];

  function automatic bit in_window(input int node, input qdl_pkg::item_t it);
    return node >= 0 && node < NodeSlots && node >= int'(it.win_first) &&
           node < int'(it.win_first) + int'(it.win_count);
  endfunction

  // Walk the shadow tree toward the sample texel and keep the deepest depth
  function automatic qdl_pkg::result_t walk_tree(input qdl_pkg::item_t it);
    qdl_pkg::result_t  r;
    int                node, next, size, half, minx, miny, cx, cy, level;
    logic [ChildW-1:0] kids;
    r.found = 1'b0;
    r.depth = qdl_pkg::DepthOne;
    node = int'($signed(it.index));
    if (node < 0 || node >= NodeSlots || it.win_count == 0 || tile_size_q == 0) return r;
    size = int'(tile_size_q);
    minx = 0;
    miny = 0;
    for (level = 0; level < MaxLevels; level++) begin
      if (!in_window(node, it)) break;
      if (depth_mem[node[SlotW-1:0]][DepthW]) begin
        r.found = 1'b1;
        r.depth = depth_mem[node[SlotW-1:0]][DepthW-1:0];
      end
      kids = child_mem[node[SlotW-1:0]];
      // stop at a leaf (all four children negative) or a unit region
      if ((kids[IndexW-1] && kids[2*IndexW-1] && kids[3*IndexW-1] && kids[4*IndexW-1]) ||
          size <= 1) break;
      half = size / 2;
      cx = (int'(it.sample_x) - minx >= half) ? 1 : 0;
      cy = (int'(it.sample_y) - miny >= half) ? 1 : 0;
      next = int'($signed(kids[(2*cy+cx)*IndexW +: IndexW]));
      if (!in_window(next, it)) break;
      node = next;
      minx += cx * half;
      miny += cy * half;
      size = half;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    qdl_pkg::item_t   it;
    qdl_pkg::result_t want;
    if (!rst_ni) begin
      tile_size_q = 13'd128;
      depth_results.delete();
      awaiting_o = 0;
    end else begin
      // compare a result beat with the oldest pending lookup
      if (m_axis_tvalid && m_axis_tready) begin
        if (depth_results.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= ReportLimit)
            $display("result beat with no lookup pending: found=%0d depth=%h",
                     m_axis_tuser[0], m_axis_tdata[DepthW-1:0]);
        end else begin
          want = depth_results.pop_front();
          if (want.found !== m_axis_tuser[0] || want.depth !== m_axis_tdata[DepthW-1:0]) begin
            mismatches_o++;
            if (mismatches_o <= ReportLimit)
              $display("lookup result wrong: expected found=%0d depth=%h, got found=%0d depth=%h",
                       want.found, want.depth, m_axis_tuser[0], m_axis_tdata[DepthW-1:0]);
          end
        end
      end
      // track the tile size
      if (cfg_valid_i && cfg_ready_i) tile_size_q = cfg_data_i;
      // apply a node write or predict a lookup
      if (s_axis_tvalid && s_axis_tready) begin
        it.op        = s_axis_tuser[0];
        it.index     = s_axis_tdata[12:0];
        it.has_depth = s_axis_tdata[13];
        it.depth     = s_axis_tdata[38:14];
        it.children  = s_axis_tdata[90:39];
        it.win_first = s_axis_tdata[102:91];
        it.win_count = s_axis_tdata[115:103];
        it.sample_x  = s_axis_tdata[127:116];
        it.sample_y  = s_axis_tdata[139:128];
        if (it.op == qdl_pkg::OpWrite) begin
          // drop writes to a negative slot or a slot past the end of the store
          if (!it.index[IndexW-1] && int'(it.index) < NodeSlots) begin
            depth_mem[it.index[SlotW-1:0]] = {it.has_depth, it.depth};
            child_mem[it.index[SlotW-1:0]] = it.children;
          end
        end else begin
          depth_results.push_back(walk_tree(it));
        end
      end
      awaiting_o = depth_results.size();
    end
  end

endmodule

[bench/tb.sv]
module tb;

  localparam int NodeSlots   = 4096;
  localparam int SlotW       = $clog2(NodeSlots);
  localparam int DrainCycles = 80;
  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 400;

  localparam int unsigned IndexW = qdl_pkg::IndexW;
  localparam int unsigned DepthW = qdl_pkg::DepthW;
  localparam int unsigned CoordW = qdl_pkg::CoordW;
  localparam int unsigned CountW = qdl_pkg::CountW;
  localparam int unsigned TileW  = qdl_pkg::TileW;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [TileW-1:0]  cfg_data_i    = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [143:0]      s_axis_tdata  = '0;
  logic [0:0]        s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;
  logic [0:0]        m_axis_tuser;

  int unsigned mismatches;
  int unsigned awaiting;
  int unsigned results_taken = 0;
  int          tile_now      = 128;
  bit          calm          = 1'b0;

  // Slots that hold a node; lookups only ever reach these
  bit slot_written [NodeSlots];
  int written_slots [$];

  always #6 clk_i = ~clk_i;

  quadtree_depth_lookup dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  qdl_depth_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches_o  (mismatches),
    .awaiting_o    (awaiting)
  );

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) results_taken++;
  end

  // Offer one input beat and hold it until accepted, then maybe idle
  task automatic send_beat(input logic op, input logic [143:0] beat);
    s_axis_tuser  <= op;
    s_axis_tdata  <= beat;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
  endtask

  function automatic logic [IndexW-1:0] noise_index();
    int v;
    v = $urandom_range(0, NodeSlots);
    return (v == NodeSlots) ? {IndexW{1'b1}} : v[IndexW-1:0];
  endfunction

  function automatic logic [DepthW-1:0] pick_depth();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return qdl_pkg::DepthOne;
    return DepthW'($urandom_range(0, 32'(qdl_pkg::DepthOne)));
  endfunction

  function automatic int pick_written();
    if (written_slots.size() == 0) return -1;
    return written_slots[$urandom_range(0, written_slots.size() - 1)];
  endfunction

  function automatic int written_or_none();
    return ($urandom_range(0, 3) == 0) ? -1 : pick_written();
  endfunction

  // Mostly inside the tile, sometimes anywhere in the field range
  function automatic int pick_coord();
    if (tile_now == 0 || $urandom_range(0, 4) == 0) return $urandom_range(0, 4095);
    return $urandom_range(0, tile_now - 1);
  endfunction

  task automatic write_node(input int slot, input logic has, input logic [DepthW-1:0] depth,
                            input int kid_a, input int kid_b, input int kid_c, input int kid_d);
    logic [IndexW-1:0] idx, ka, kb, kc, kd;
    logic [CoordW-1:0] gf, gx, gy;
    logic [CountW-1:0] gc;
    idx = slot[IndexW-1:0];
    ka  = kid_a[IndexW-1:0];
    kb  = kid_b[IndexW-1:0];
    kc  = kid_c[IndexW-1:0];
    kd  = kid_d[IndexW-1:0];
    gf  = CoordW'($urandom_range(0, 4095));
    gc  = CountW'($urandom_range(0, NodeSlots));
    gx  = CoordW'($urandom_range(0, 4095));
    gy  = CoordW'($urandom_range(0, 4095));
    send_beat(qdl_pkg::OpWrite, {4'b0, gy, gx, gc, gf, kd, kc, kb, ka, depth, has, idx});
    if (slot >= 0 && !slot_written[slot[SlotW-1:0]]) begin
      slot_written[slot[SlotW-1:0]] = 1'b1;
      written_slots.push_back(slot);
    end
  endtask

  task automatic probe(input int root, input int first, input int count,
                       input int sx, input int sy);
    logic [IndexW-1:0] idx;
    logic [CoordW-1:0] f, x, y;
    logic [CountW-1:0] c;
    logic [DepthW-1:0] junk_depth;
    logic              junk_has;
    idx        = root[IndexW-1:0];
    f          = first[CoordW-1:0];
    c          = count[CountW-1:0];
    x          = sx[CoordW-1:0];
    y          = sy[CoordW-1:0];
    junk_depth = DepthW'($urandom_range(0, 32'(qdl_pkg::DepthOne)));
    junk_has   = 1'($urandom_range(0, 1));
    send_beat(qdl_pkg::OpLookup, {4'b0, y, x, c, f, noise_index(), noise_index(),
                                  noise_index(), noise_index(), junk_depth, junk_has, idx});
  endtask

  // Write a small tree leaves first, so every child is none or points at a written slot
  task automatic build_tree(input int base, input int n);
    int kids [4];
    int k, j, roll;
    for (k = n - 1; k >= 0; k--) begin
      for (j = 0; j < 4; j++) begin
        roll = $urandom_range(0, 19);
        if (roll < 5) kids[j] = -1;
        else if (roll < 15) kids[j] = (k + 1 < n) ? base + k + 1 : -1;
        else if (roll < 18) kids[j] = (k + 1 < n) ? base + $urandom_range(k + 1, n - 1) : -1;
        else kids[j] = pick_written();
      end
      write_node(base + k, $urandom_range(0, 9) < 7, pick_depth(),
                 kids[0], kids[1], kids[2], kids[3]);
    end
  endtask

  task automatic run_phase(input int items);
    int sent, base, n, roll, probes, p, root, first, count;
    sent = 0;
    while (sent < items) begin
      roll = $urandom_range(0, 19);
      if (roll < 14) begin
        // tree followed by a few lookups into it
        n = $urandom_range(2, 14);
        base = $urandom_range(0, NodeSlots - n);
        build_tree(base, n);
        probes = $urandom_range(2, 6);
        for (p = 0; p < probes; p++) begin
          root  = base;
          first = base;
          count = n;
          roll = $urandom_range(0, 19);
          if (roll < 2) root = base + $urandom_range(1, n - 1);
          else if (roll == 2) root = -1;
          roll = $urandom_range(0, 19);
          if (roll < 3) count = $urandom_range(1, n);
          else if (roll < 6) begin
            first = $urandom_range(0, base);
            count = $urandom_range(1, NodeSlots);
          end else if (roll == 6) count = 0;
          probe(root, first, count, pick_coord(), pick_coord());
        end
        sent += n + probes;
      end else if (roll < 17) begin
        // lookup from a written node or the none slot with a random window
        probe(written_or_none(), $urandom_range(0, 4095), $urandom_range(0, NodeSlots),
              $urandom_range(0, 4095), $urandom_range(0, 4095));
        sent++;
      end else if (roll < 19) begin
        // overwrite a known node
        root = pick_written();
        write_node(root, 1'($urandom_range(0, 1)), pick_depth(), written_or_none(),
                   written_or_none(), written_or_none(), written_or_none());
        if (root >= 0) sent++;
      end else begin
        // write to the none slot, dropped by the block
        write_node(-1, 1'($urandom_range(0, 1)), pick_depth(), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
      end
    end
  endtask

  // Stop offering, wait for all results, then let a trailing write retire
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_tile(input int value);
    settle();
    cfg_data_i  <= value[TileW-1:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    tile_now = value;
  endtask

  initial begin : stimulus
    int tiles [10];
    int ph;
    tiles = '{4096, 1, 0, 2, 3, 64, 4095, 0, 256, 128};
    tiles[7] = $urandom_range(1, 4096);
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed nodes at the reset tile size
    write_node(0, 1'b1, qdl_pkg::DepthOne, -1, -1, -1, -1);
    write_node(NodeSlots - 1, 1'b1, '0, -1, -1, -1, -1);
    write_node(-1, 1'b1, 25'h0AB_CDEF, 0, 0, 0, 0);
    write_node(2, 1'b1, 25'h012_3456, -1, -1, -1, -1);
    write_node(3, 1'b0, '0, 4095, 4095, 4095, 4095);
    write_node(4, 1'b1, qdl_pkg::DepthOne, -1, -1, -1, -1);
    write_node(5, 1'b1, 25'h0FF_FFFF, 0, -1, -1, -1);
    write_node(1, 1'b1, 25'h080_0000, 2, 3, 4, 5);

    // Directed lookups: leaves, extremes, rejects, each quadrant, window exits
    probe(0, 0, 1, 0, 0);
    probe(4095, 4095, 1, 4095, 4095);
    probe(4095, 0, 4096, 0, 0);
    probe(-1, 0, 4096, 0, 0);
    probe(1, 1, 0, 0, 0);
    probe(1, 1, 5, 0, 0);
    probe(1, 1, 5, 127, 0);
    probe(1, 1, 5, 0, 127);
    probe(1, 1, 5, 4095, 4095);
    probe(1, 1, 1, 0, 0);
    probe(3, 0, 4096, 64, 64);
    probe(5, 0, 6, 127, 127);
    probe(5, 0, 6, 0, 0);

    // Random phases over several tile sizes; the last one runs without idling
    for (ph = 0; ph < 10; ph++) begin
      set_tile(tiles[ph]);
      if (ph == 9) calm = 1'b1;
      run_phase((tiles[ph] == 0) ? 60 : 190);
    end

    settle();
    if (mismatches == 0 && awaiting == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Result side: short random stalls, one long hold-off to back up the block
  initial begin : receiver
    bit squeezed;
    squeezed = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!squeezed && results_taken >= 100) begin
        squeezed = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
